>>> rtl/core/scc_pkg.sv
// Shared types and constants for the strongly connected components core.
package scc_pkg;

  // Width of a node index field on the ports.
  localparam int IDX_W = 6;
  // Width of the node count register.
  localparam int CFG_W = 7;
  // Node count after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // One input item: a directed edge, possibly the last one of the graph.
  typedef struct packed {
    logic [IDX_W-1:0] edge_from;
    logic [IDX_W-1:0] edge_to;
    logic             final_edge;
  } in_item_t;

  // One result item: the component root of one node.
  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] component;
    logic             last_node;
  } out_item_t;

endpackage

>>> rtl/core/scc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module scc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/strongly_connected_components_core.sv
// Top level of the strongly connected components core (Tarjan search over a bit matrix).
//
// Usage: the graph is sent one edge per input item on the in_* valid/ready channel.
// Each edge is a row read followed by a row write; edges with an endpoint of
// MAX_NODES or more are dropped. The item with final_edge set loads its edge and then
// starts the search, during which in_ready_o stays low.
// The search is run by one small sequencer that tests one adjacency bit per cycle,
// pausing for frame push, pop and low-link updates. Every adjacency row is held in a RAM.
// After the search one result item per node leaves on the out_* channel in node order;
// last_node marks the final node.
// A stalled receiver simply holds the result register and the sequencer waits.
// After the last item is taken, a clearing pass zeroes every row of the matrix
// before the next edge is accepted.
// The node_count register (cfg_we_i / cfg_wdata_i) must be written while the core is
// idle; the core does not enforce this. Zero acts as one and values above MAX_NODES
// act as MAX_NODES. Reset (rst_ni low) sets node_count to 64 and starts the same
// clearing pass, so in_ready_o rises only once the matrix RAM is all zero.
module strongly_connected_components_core #(
  parameter int MAX_NODES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [scc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  scc_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output scc_pkg::out_item_t       out_data_o
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int FW = NW + CW;
  localparam int IdxW = scc_pkg::IDX_W;

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_EDGE_WR = 20'h00002,
    ST_OUTER   = 20'h00004,
    ST_FRAME   = 20'h00008,
    ST_FRAME_D = 20'h00010,
    ST_ROW     = 20'h00020,
    ST_SCAN    = 20'h00040,
    ST_CMP     = 20'h00080,
    ST_PUSH    = 20'h00100,
    ST_FIN_D   = 20'h00200,
    ST_POP     = 20'h00400,
    ST_POP_D   = 20'h00800,
    ST_RET     = 20'h01000,
    ST_RET_P   = 20'h02000,
    ST_RET_L   = 20'h04000,
    ST_EMIT    = 20'h08000,
    ST_EMIT_D  = 20'h10000,
    ST_EMIT_W  = 20'h20000,
    ST_CLEAR   = 20'h40000,
    ST_SPARE   = 20'h80000
  } state_e;

  state_e state_q, state_d;

  logic [scc_pkg::CFG_W-1:0] node_count_q;
  logic [CW-1:0]             n_eff;

  logic [CW-1:0] s_q, s_d, csp_q, csp_d, ssp_q, ssp_d, w_q, w_d, cnt_q, cnt_d, i_q, i_d;
  logic [NW-1:0] v_q, v_d, llv_q, llv_d, p_q, p_d, from_q, from_d, to_q, to_d, clr_q, clr_d;
  logic          ok_q, ok_d, fin_q, fin_d;
  logic [MAX_NODES-1:0] row_q, row_d, visited_q, visited_d, on_q, on_d;
  scc_pkg::out_item_t res_q, res_d;
  logic               res_valid_q, res_valid_d;

  // Memory ports.
  logic                 adj_we, vo_we, ll_we, scc_we, call_we, lab_we;
  logic [NW-1:0]        adj_wa, adj_ra, vo_wa, vo_ra, ll_wa, ll_ra;
  logic [NW-1:0]        scc_wa, scc_ra, call_wa, call_ra, lab_wa, lab_ra;
  logic [MAX_NODES-1:0] adj_wd, adj_rd;
  logic [NW-1:0]        vo_wd, vo_rd, ll_wd, ll_rd, scc_wd, scc_rd, lab_wd, lab_rd;
  logic [FW-1:0]        call_wd, call_rd;

  // Discovery of a new node.
  logic          disc;
  logic [NW-1:0] disc_node;

  // Effective node count, clamped to one through MAX_NODES.
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    csp_d       = csp_q;
    ssp_d       = ssp_q;
    w_d         = w_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    v_d         = v_q;
    llv_d       = llv_q;
    p_d         = p_q;
    from_d      = from_q;
    to_d        = to_q;
    clr_d       = clr_q;
    ok_d        = ok_q;
    fin_d       = fin_q;
    row_d       = row_q;
    visited_d   = visited_q;
    on_d        = on_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
    vo_we  = 1'b0; vo_wa  = '0; vo_wd  = '0; vo_ra  = '0;
    ll_we  = 1'b0; ll_wa  = '0; ll_wd  = '0; ll_ra  = '0;
    scc_we = 1'b0; scc_wa = '0; scc_wd = '0; scc_ra = '0;
    call_we = 1'b0; call_wa = '0; call_wd = '0; call_ra = '0;
    lab_we = 1'b0; lab_wa = '0; lab_wd = '0; lab_ra = '0;
    disc      = 1'b0;
    disc_node = '0;

    case (state_q)
      ST_IDLE: begin
        adj_ra = in_data_i.edge_from[NW-1:0];
        if (in_valid_i) begin
          from_d  = in_data_i.edge_from[NW-1:0];
          to_d    = in_data_i.edge_to[NW-1:0];
          ok_d    = (32'(in_data_i.edge_from) < MAX_NODES) &&
                    (32'(in_data_i.edge_to) < MAX_NODES);
          fin_d   = in_data_i.final_edge;
          state_d = ST_EDGE_WR;
        end
      end
      ST_EDGE_WR: begin
        adj_we = ok_q;
        adj_wa = from_q;
        adj_wd = adj_rd | (MAX_NODES'(1) << to_q);
        if (fin_q) begin
          s_d     = '0;
          state_d = ST_OUTER;
        end else begin
          state_d = ST_IDLE;
        end
      end
      // Walk the root candidates in index order.
      ST_OUTER: begin
        if (s_q == n_eff) begin
          i_d     = '0;
          state_d = ST_EMIT;
        end else if (visited_q[s_q[NW-1:0]]) begin
          s_d = s_q + CW'(1);
        end else begin
          disc      = 1'b1;
          disc_node = s_q[NW-1:0];
          call_we   = 1'b1;
          call_wa   = '0;
          call_wd   = {s_q[NW-1:0], CW'(0)};
          csp_d     = CW'(1);
          state_d   = ST_FRAME;
        end
      end
      ST_FRAME: begin
        call_ra = NW'(csp_q - CW'(1));
        state_d = ST_FRAME_D;
      end
      ST_FRAME_D: begin
        v_d     = call_rd[FW-1:CW];
        w_d     = call_rd[CW-1:0];
        adj_ra  = call_rd[FW-1:CW];
        ll_ra   = call_rd[FW-1:CW];
        state_d = ST_ROW;
      end
      ST_ROW: begin
        row_d   = adj_rd;
        llv_d   = ll_rd;
        state_d = ST_SCAN;
      end
      // One neighbor bit per cycle, paused while a low-link compare or a frame push runs.
      ST_SCAN: begin
        if (w_q >= n_eff) begin
          vo_ra   = v_q;
          state_d = ST_FIN_D;
        end else if (!row_q[w_q[NW-1:0]]) begin
          w_d = w_q + CW'(1);
        end else if (!visited_q[w_q[NW-1:0]]) begin
          call_we   = 1'b1;
          call_wa   = NW'(csp_q - CW'(1));
          call_wd   = {v_q, w_q + CW'(1)};
          disc      = 1'b1;
          disc_node = w_q[NW-1:0];
          if (32'(csp_q) < MAX_NODES) begin
            v_d     = w_q[NW-1:0];
            state_d = ST_PUSH;
          end else begin
            state_d = ST_FRAME;
          end
        end else if (on_q[w_q[NW-1:0]]) begin
          vo_ra   = w_q[NW-1:0];
          state_d = ST_CMP;
        end else begin
          w_d = w_q + CW'(1);
        end
      end
      ST_CMP: begin
        if (vo_rd < llv_q) begin
          ll_we = 1'b1;
          ll_wa = v_q;
          ll_wd = vo_rd;
          llv_d = vo_rd;
        end
        w_d     = w_q + CW'(1);
        state_d = ST_SCAN;
      end
      ST_PUSH: begin
        call_we = 1'b1;
        call_wa = NW'(csp_q);
        call_wd = {v_q, CW'(0)};
        csp_d   = csp_q + CW'(1);
        w_d     = '0;
        adj_ra  = v_q;
        ll_ra   = v_q;
        state_d = ST_ROW;
      end
      // Node finished: is it a component root?
      ST_FIN_D: begin
        state_d = (llv_q == vo_rd) ? ST_POP : ST_RET;
      end
      ST_POP: begin
        if (ssp_q == '0) begin
          state_d = ST_RET;
        end else begin
          scc_ra  = NW'(ssp_q - CW'(1));
          ssp_d   = ssp_q - CW'(1);
          state_d = ST_POP_D;
        end
      end
      ST_POP_D: begin
        lab_we      = 1'b1;
        lab_wa      = scc_rd;
        lab_wd      = v_q;
        on_d[scc_rd] = 1'b0;
        state_d     = (scc_rd == v_q) ? ST_RET : ST_POP;
      end
      // Return to the parent frame and fold the low-link upward.
      ST_RET: begin
        csp_d = csp_q - CW'(1);
        if (csp_q != CW'(1)) begin
          call_ra = NW'(csp_q - CW'(2));
          state_d = ST_RET_P;
        end else begin
          s_d     = s_q + CW'(1);
          state_d = ST_OUTER;
        end
      end
      ST_RET_P: begin
        p_d     = call_rd[FW-1:CW];
        ll_ra   = call_rd[FW-1:CW];
        state_d = ST_RET_L;
      end
      ST_RET_L: begin
        if (llv_q < ll_rd) begin
          ll_we = 1'b1;
          ll_wa = p_q;
          ll_wd = llv_q;
        end
        state_d = ST_FRAME;
      end
      // Result items, one per node.
      ST_EMIT: begin
        lab_ra  = i_q[NW-1:0];
        state_d = ST_EMIT_D;
      end
      ST_EMIT_D: begin
        res_d.node      = IdxW'(i_q[NW-1:0]);
        res_d.component = IdxW'(lab_rd);
        res_d.last_node = (i_q == n_eff - CW'(1));
        res_valid_d     = 1'b1;
        state_d         = ST_EMIT_W;
      end
      ST_EMIT_W: begin
        if (out_ready_i) begin
          res_valid_d = 1'b0;
          if (i_q == n_eff - CW'(1)) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = ST_EMIT;
          end
        end
      end
      // Clear the matrix one row a cycle and drop the search marks.
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_wa    = clr_q;
        adj_wd    = '0;
        visited_d = '0;
        on_d      = '0;
        cnt_d     = '0;
        ssp_d     = '0;
        clr_d     = clr_q + NW'(1);
        if (32'(clr_q) == MAX_NODES - 1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Give a newly reached node its discovery number and push it on the component stack.
    if (disc) begin
      vo_we = 1'b1;
      vo_wa = disc_node;
      vo_wd = cnt_q[NW-1:0];
      ll_we = 1'b1;
      ll_wa = disc_node;
      ll_wd = cnt_q[NW-1:0];
      llv_d = cnt_q[NW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (32'(ssp_q) < MAX_NODES) begin
        scc_we = 1'b1;
        scc_wa = NW'(ssp_q);
        scc_wd = disc_node;
        ssp_d  = ssp_q + CW'(1);
      end
      on_d[disc_node]      = 1'b1;
      visited_d[disc_node] = 1'b1;
    end
  end

  // Control registers; reset starts with a clearing pass over the matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      node_count_q <= scc_pkg::CFG_RESET;
      s_q          <= '0;
      csp_q        <= '0;
      ssp_q        <= '0;
      cnt_q        <= '0;
      i_q          <= '0;
      clr_q        <= '0;
      ok_q         <= 1'b0;
      fin_q        <= 1'b0;
      visited_q    <= '0;
      on_q         <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      s_q         <= s_d;
      csp_q       <= csp_d;
      ssp_q       <= ssp_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      clr_q       <= clr_d;
      ok_q        <= ok_d;
      fin_q       <= fin_d;
      visited_q   <= visited_d;
      on_q        <= on_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    v_q    <= v_d;
    llv_q  <= llv_d;
    p_q    <= p_d;
    from_q <= from_d;
    to_q   <= to_d;
    row_q  <= row_d;
    res_q  <= res_d;
  end

  // Adjacency matrix, one row per node.
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(MAX_NODES)) u_adj (
    .clk_i(clk_i), .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd)
  );

  // Discovery numbers.
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_visit (
    .clk_i(clk_i), .we_i(vo_we), .waddr_i(vo_wa), .wdata_i(vo_wd),
    .raddr_i(vo_ra), .rdata_o(vo_rd)
  );

  // Low-link values.
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_low (
    .clk_i(clk_i), .we_i(ll_we), .waddr_i(ll_wa), .wdata_i(ll_wd),
    .raddr_i(ll_ra), .rdata_o(ll_rd)
  );

  // Component stack.
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_stack (
    .clk_i(clk_i), .we_i(scc_we), .waddr_i(scc_wa), .wdata_i(scc_wd),
    .raddr_i(scc_ra), .rdata_o(scc_rd)
  );

  // Call stack frames: node and next neighbor to test.
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(FW)) u_call (
    .clk_i(clk_i), .we_i(call_we), .waddr_i(call_wa), .wdata_i(call_wd),
    .raddr_i(call_ra), .rdata_o(call_rd)
  );

  // Component labels.
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_label (
    .clk_i(clk_i), .we_i(lab_we), .waddr_i(lab_wa), .wdata_i(lab_wd),
    .raddr_i(lab_ra), .rdata_o(lab_rd)
  );

endmodule
